// ===== hw/rtl/sfd_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfd_pkg: shared types and constants of the sensor frame deframer
// Parser modes, event codes, register indexes, the configuration bundle and
// the byte-wide reflected CRC-16 step.
// ----------------------------------------------------------------------------
package sfd_pkg;

    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'h8408;

    typedef enum logic [1:0] {
        MODE_HEADER = 2'd0,
        MODE_ID     = 2'd1,
        MODE_DATA   = 2'd2,
        MODE_CRC    = 2'd3
    } mode_t;

    typedef enum logic [2:0] {
        EV_NONE    = 3'd0,
        EV_PAYLOAD = 3'd1,
        EV_CRC_HI  = 3'd2,
        EV_GOOD    = 3'd3,
        EV_BAD     = 3'd4,
        EV_DROP    = 3'd5
    } event_t;

    typedef enum logic [1:0] {
        CFG_HEADER  = 2'd0,
        CFG_SLOW_ID = 2'd1,
        CFG_FAST_ID = 2'd2,
        CFG_SPARE   = 2'd3
    } cfg_index_t;

    typedef struct packed {
        logic [7:0] header_byte;
        logic [7:0] slow_frame_id;
        logic [7:0] fast_frame_id;
    } cfg_t;

    // One byte through the reflected CRC, LSB first.
    function automatic logic [15:0] crc16_byte(input logic [15:0] seed,
                                               input logic [7:0]  data);
        logic [15:0] crc;
        crc = seed ^ {8'h00, data};
        for (int i = 0; i < 8; i++) begin
            if (crc[0])
                crc = (crc >> 1) ^ CRC_POLY;
            else
                crc = crc >> 1;
        end
        return crc;
    endfunction

endpackage

// ===== hw/rtl/sfd_cfg_regs.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfd_cfg_regs: configuration registers
// Header byte and the two frame identifiers, written through a plain port.
// ----------------------------------------------------------------------------
module sfd_cfg_regs (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_write,
    input  logic [1:0]  cfg_index,
    input  logic [7:0]  cfg_data,
    output sfd_pkg::cfg_t cfg
);

    sfd_pkg::cfg_t cfg_reg;
    sfd_pkg::cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write)
        begin
            unique case (sfd_pkg::cfg_index_t'(cfg_index))
                sfd_pkg::CFG_HEADER:  cfg_next.header_byte   = cfg_data;
                sfd_pkg::CFG_SLOW_ID: cfg_next.slow_frame_id = cfg_data;
                sfd_pkg::CFG_FAST_ID: cfg_next.fast_frame_id = cfg_data;
                sfd_pkg::CFG_SPARE:   cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cfg_reg <= '0;
        else
            cfg_reg <= cfg_next;
    end

    assign cfg = cfg_reg;

endmodule

// ===== hw/rtl/sfd_parser.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfd_parser: frame parser and result register
// Runs the header / identifier / payload / CRC sequence on one byte per
// cycle while out_stall does not hold the result register, and registers the event for the output channel.
// ----------------------------------------------------------------------------
module sfd_parser #(
    parameter int SLOW_PAYLOAD_LEN = 24,
    parameter int FAST_PAYLOAD_LEN = 36
) (
    input  logic          clk,
    input  logic          rst_n,
    input  sfd_pkg::cfg_t cfg,
    input  logic          step_valid,
    input  logic [7:0]    step_byte,
    input  logic          step_hold_slow,
    input  logic          step_hold_fast,
    output logic          step_ready,
    output logic          out_valid,
    input  logic          out_stall,
    output logic [2:0]    event_kind,
    output logic          frame_kind,
    output logic [5:0]    byte_index,
    output logic [7:0]    byte_value,
    output logic [15:0]   computed_crc
);

    localparam logic [5:0] SLOW_LEN = 6'(SLOW_PAYLOAD_LEN);
    localparam logic [5:0] FAST_LEN = 6'(FAST_PAYLOAD_LEN);

    sfd_pkg::mode_t  mode_reg, mode_next;
    logic [5:0]      count_reg, count_next;
    logic            fast_reg, fast_next;
    logic [15:0]     crc_reg, crc_next;
    logic [15:0]     rx_crc_reg, rx_crc_next;

    logic            out_valid_reg, out_valid_next;
    sfd_pkg::event_t ev_reg, ev_next;
    logic            fk_reg, fk_next;
    logic [5:0]      idx_reg, idx_next;
    logic [7:0]      val_reg, val_next;
    logic [15:0]     ccrc_reg, ccrc_next;

    logic            advance;
    logic            fire;
    logic [5:0]      cur_len;
    logic [5:0]      count_inc;
    logic [15:0]     crc_seed;
    logic [15:0]     crc_byte;
    logic            match_slow;
    logic            match_fast;
    logic            held;
    logic [15:0]     rx_crc_full;

    // Move on when the result register is empty or being drained.
    assign advance    = !out_valid_reg || !out_stall;
    assign fire       = step_valid && advance;
    assign step_ready = advance;

    assign cur_len     = fast_reg ? FAST_LEN : SLOW_LEN;
    assign count_inc   = count_reg + 6'd1;
    assign crc_seed    = (mode_reg == sfd_pkg::MODE_HEADER) ? sfd_pkg::CRC_INIT : crc_reg;
    assign crc_byte    = sfd_pkg::crc16_byte(crc_seed, step_byte);
    assign match_slow  = (step_byte == cfg.slow_frame_id);
    assign match_fast  = (step_byte == cfg.fast_frame_id);
    // Slow identifier wins when both match.
    assign held        = match_slow ? step_hold_slow : step_hold_fast;
    assign rx_crc_full = {rx_crc_reg[15:8], step_byte};

    always_comb
    begin
        mode_next   = mode_reg;
        count_next  = count_reg;
        fast_next   = fast_reg;
        crc_next    = crc_reg;
        rx_crc_next = rx_crc_reg;
        ev_next     = sfd_pkg::EV_NONE;
        fk_next     = 1'b0;
        idx_next    = 6'd0;

        unique case (mode_reg)
            sfd_pkg::MODE_HEADER:
            begin
                if (step_byte == cfg.header_byte)
                begin
                    mode_next  = sfd_pkg::MODE_ID;
                    count_next = 6'd0;
                    fast_next  = 1'b0;
                    crc_next   = crc_byte;
                end
            end
            sfd_pkg::MODE_ID:
            begin
                if (match_slow || match_fast)
                begin
                    if (held)
                    begin
                        mode_next = sfd_pkg::MODE_HEADER;
                        ev_next   = sfd_pkg::EV_DROP;
                        fk_next   = !match_slow;
                    end
                    else
                    begin
                        mode_next  = sfd_pkg::MODE_DATA;
                        fast_next  = !match_slow;
                        count_next = 6'd0;
                        crc_next   = crc_byte;
                    end
                end
                else
                begin
                    mode_next = sfd_pkg::MODE_HEADER;
                end
            end
            sfd_pkg::MODE_DATA:
            begin
                crc_next   = crc_byte;
                ev_next    = sfd_pkg::EV_PAYLOAD;
                fk_next    = fast_reg;
                idx_next   = count_reg;
                count_next = count_inc;
                if (count_inc >= cur_len)
                    mode_next = sfd_pkg::MODE_CRC;
            end
            sfd_pkg::MODE_CRC:
            begin
                fk_next  = fast_reg;
                idx_next = count_reg;
                if (count_reg == cur_len)
                begin
                    rx_crc_next = {step_byte, rx_crc_reg[7:0]};
                    count_next  = count_inc;
                    ev_next     = sfd_pkg::EV_CRC_HI;
                end
                else
                begin
                    rx_crc_next = rx_crc_full;
                    ev_next     = (rx_crc_full == crc_reg) ? sfd_pkg::EV_GOOD
                                                           : sfd_pkg::EV_BAD;
                    mode_next   = sfd_pkg::MODE_HEADER;
                end
            end
        endcase
    end

    // Result register: load on a fired step, hold while stalled.
    always_comb
    begin
        out_valid_next = out_valid_reg;
        val_next       = val_reg;
        ccrc_next      = ccrc_reg;
        if (advance)
            out_valid_next = step_valid;
        if (fire)
        begin
            val_next  = step_byte;
            ccrc_next = crc_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= sfd_pkg::MODE_HEADER;
            count_reg     <= 6'd0;
            fast_reg      <= 1'b0;
            crc_reg       <= sfd_pkg::CRC_INIT;
            rx_crc_reg    <= 16'h0000;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (fire)
            begin
                mode_reg   <= mode_next;
                count_reg  <= count_next;
                fast_reg   <= fast_next;
                crc_reg    <= crc_next;
                rx_crc_reg <= rx_crc_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            ev_reg  <= ev_next;
            fk_reg  <= fk_next;
            idx_reg <= idx_next;
        end
        val_reg  <= val_next;
        ccrc_reg <= ccrc_next;
    end

    assign out_valid    = out_valid_reg;
    assign event_kind   = ev_reg;
    assign frame_kind   = fk_reg;
    assign byte_index   = idx_reg;
    assign byte_value   = val_reg;
    assign computed_crc = ccrc_reg;

    a_data_count_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (mode_reg == sfd_pkg::MODE_DATA) |-> (count_reg < cur_len))
        else $error("payload count beyond frame length");

    a_crc_count_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (mode_reg == sfd_pkg::MODE_CRC) |->
            (count_reg == cur_len || count_reg == cur_len + 6'd1))
        else $error("crc byte count out of step");

    a_data_gives_payload: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && mode_reg == sfd_pkg::MODE_DATA) |=>
            (out_valid_reg && ev_reg == sfd_pkg::EV_PAYLOAD))
        else $error("payload byte did not give a payload event");

    a_none_fields_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && ev_reg == sfd_pkg::EV_NONE) |-> (!fk_reg && idx_reg == 6'd0))
        else $error("empty event carries frame fields");

    a_verdict_returns_to_hunt: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && mode_reg == sfd_pkg::MODE_CRC && count_reg != cur_len) |=>
            (mode_reg == sfd_pkg::MODE_HEADER))
        else $error("parser did not return to header hunt after crc");

endmodule

// ===== hw/rtl/sensor_frame_deframer_crc16.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sensor_frame_deframer_crc16: serial frame deframer with CRC-16 check
// Input register, configuration registers and the frame parser.
// ----------------------------------------------------------------------------
// Each byte taken gives exactly one result: the byte is registered in the input
// register, then goes through the parser and CRC step into the result register.
// Throughput is one byte per cycle as long as out_stall stays low; the parser
// state and the byte-wide CRC-16 update (poly 0x8408, init 0xFFFF, reflected)
// are combinational. A frame is header, identifier, payload of SLOW_PAYLOAD_LEN
// or FAST_PAYLOAD_LEN bytes and two CRC bytes, high byte first; the second CRC
// byte reports good or bad.
// Write the configuration registers only while no byte is in flight.
module sensor_frame_deframer_crc16 #(
    parameter int SLOW_PAYLOAD_LEN = 24,
    parameter int FAST_PAYLOAD_LEN = 36
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_write,
    input  logic [1:0]  cfg_index,
    input  logic [7:0]  cfg_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  rx_byte,
    input  logic        hold_slow,
    input  logic        hold_fast,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [2:0]  event_kind,
    output logic        frame_kind,
    output logic [5:0]  byte_index,
    output logic [7:0]  byte_value,
    output logic [15:0] computed_crc
);

    sfd_pkg::cfg_t cfg;

    logic       s1_valid_reg, s1_valid_next;
    logic [7:0] s1_byte_reg;
    logic       s1_hold_slow_reg;
    logic       s1_hold_fast_reg;
    logic       step_ready;
    logic       in_take;

    assign in_stall = s1_valid_reg && !step_ready;
    assign in_take  = in_valid && !in_stall;

    // Refill on a transfer, otherwise empty once the parser takes the byte.
    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (in_take)
            s1_valid_next = 1'b1;
        else if (step_ready)
            s1_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else
            s1_valid_reg <= s1_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            s1_byte_reg      <= rx_byte;
            s1_hold_slow_reg <= hold_slow;
            s1_hold_fast_reg <= hold_fast;
        end
    end

    sfd_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    sfd_parser #(
        .SLOW_PAYLOAD_LEN (SLOW_PAYLOAD_LEN),
        .FAST_PAYLOAD_LEN (FAST_PAYLOAD_LEN)
    ) u_parser (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg            (cfg),
        .step_valid     (s1_valid_reg),
        .step_byte      (s1_byte_reg),
        .step_hold_slow (s1_hold_slow_reg),
        .step_hold_fast (s1_hold_fast_reg),
        .step_ready     (step_ready),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .event_kind     (event_kind),
        .frame_kind     (frame_kind),
        .byte_index     (byte_index),
        .byte_value     (byte_value),
        .computed_crc   (computed_crc)
    );

endmodule

// ===== tb/sv/tb_sensor_frame_deframer_crc16.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_sensor_frame_deframer_crc16: self-checking bench for the frame deframer
// Drives received bytes over the valid/stall input channel and checks every
// result against an in-bench model of the parser and its reflected CRC-16.
// A short stimulus table comes first, then random frames with noise and
// broken sequences under three configurations and three idling profiles.
// ----------------------------------------------------------------------------
module tb_sensor_frame_deframer_crc16;

    localparam int SLOW_LEN = 24;
    localparam int FAST_LEN = 36;

    typedef enum logic [1:0] {
        SRC_LIT     = 2'd0,
        SRC_CRC_HI  = 2'd1,
        SRC_CRC_LO  = 2'd2,
        SRC_CRC_BAD = 2'd3
    } byte_src_t;

    typedef struct packed {
        byte_src_t       src;
        logic [7:0]      lit;
        logic            hs;
        logic            hf;
        logic [5:0]      reps;
        logic            pinned;
        sfd_pkg::event_t kind;
        logic            fk;
        logic [5:0]      idx;
    } stim_row_t;

    typedef struct packed {
        sfd_pkg::event_t kind;
        logic            fk;
        logic [5:0]      idx;
        logic [7:0]      val;
        logic [15:0]     crc;
    } deframe_result_t;

    logic                clk = 1'b0;
    logic                rst_n;
    logic                cfg_write;
    sfd_pkg::cfg_index_t cfg_index;
    logic [7:0]          cfg_data;
    logic                in_valid;
    logic                in_stall;
    logic [7:0]          rx_byte;
    logic                hold_slow;
    logic                hold_fast;
    logic                out_valid;
    logic                out_stall = 1'b0;
    logic [2:0]          event_kind;
    logic                frame_kind;
    logic [5:0]          byte_index;
    logic [7:0]          byte_value;
    logic [15:0]         computed_crc;

    // register shadows and parser state of the model
    logic [7:0]      reg_header    = 8'h00;
    logic [7:0]      reg_slow_id   = 8'h00;
    logic [7:0]      reg_fast_id   = 8'h00;
    sfd_pkg::mode_t  parse_mode    = sfd_pkg::MODE_HEADER;
    logic [5:0]      payload_count = 6'd0;
    logic            in_fast_frame = 1'b0;
    logic [15:0]     run_crc       = sfd_pkg::CRC_INIT;
    logic [15:0]     heard_crc     = 16'h0000;

    deframe_result_t pending_results [$];
    int mismatches     = 0;
    int bytes_taken    = 0;
    int src_gap_pct    = 0;
    int sink_stall_pct = 0;

    // Header, identifiers and CRC bytes all refer to the reset configuration,
    // where header and both identifiers are zero.
    stim_row_t directed_rows [13] = '{
        // byte that is not the header: ignored
        '{SRC_LIT, 8'hFF, 1'b0, 1'b0, 6'd1, 1'b1, sfd_pkg::EV_NONE, 1'b0, 6'd0},
        '{SRC_LIT, 8'h00, 1'b1, 1'b1, 6'd1, 1'b1, sfd_pkg::EV_NONE, 1'b0, 6'd0},
        // unknown identifier: back to hunting
        '{SRC_LIT, 8'hFF, 1'b0, 1'b0, 6'd1, 1'b1, sfd_pkg::EV_NONE, 1'b0, 6'd0},
        '{SRC_LIT, 8'h00, 1'b0, 1'b0, 6'd1, 1'b1, sfd_pkg::EV_NONE, 1'b0, 6'd0},
        // both identifiers equal, slow wins and its buffer is held
        '{SRC_LIT, 8'h00, 1'b1, 1'b0, 6'd1, 1'b1, sfd_pkg::EV_DROP, 1'b0, 6'd0},
        '{SRC_LIT, 8'h00, 1'b0, 1'b0, 6'd1, 1'b1, sfd_pkg::EV_NONE, 1'b0, 6'd0},
        // slow frame taken, fast hold is irrelevant
        '{SRC_LIT, 8'h00, 1'b0, 1'b1, 6'd1, 1'b1, sfd_pkg::EV_NONE, 1'b0, 6'd0},
        // header value inside the payload is plain data
        '{SRC_LIT, 8'h00, 1'b0, 1'b0, 6'd1, 1'b1, sfd_pkg::EV_PAYLOAD, 1'b0, 6'd0},
        '{SRC_LIT, 8'hFF, 1'b1, 1'b1, 6'd22, 1'b0, sfd_pkg::EV_NONE, 1'b0, 6'd0},
        '{SRC_LIT, 8'hA5, 1'b0, 1'b0, 6'd1, 1'b1, sfd_pkg::EV_PAYLOAD, 1'b0, 6'd23},
        '{SRC_CRC_HI, 8'h00, 1'b0, 1'b0, 6'd1, 1'b1, sfd_pkg::EV_CRC_HI, 1'b0, 6'd24},
        '{SRC_CRC_LO, 8'h00, 1'b0, 1'b0, 6'd1, 1'b1, sfd_pkg::EV_GOOD, 1'b0, 6'd25},
        '{SRC_LIT, 8'h7E, 1'b1, 1'b0, 6'd1, 1'b1, sfd_pkg::EV_NONE, 1'b0, 6'd0}
    };

    sensor_frame_deframer_crc16 #(
        .SLOW_PAYLOAD_LEN(SLOW_LEN),
        .FAST_PAYLOAD_LEN(FAST_LEN)
    ) DUT (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_write(cfg_write),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .rx_byte(rx_byte),
        .hold_slow(hold_slow),
        .hold_fast(hold_fast),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .event_kind(event_kind),
        .frame_kind(frame_kind),
        .byte_index(byte_index),
        .byte_value(byte_value),
        .computed_crc(computed_crc)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    function automatic logic rand_bit();
        return 1'($urandom_range(1));
    endfunction

    function automatic logic [7:0] rand_byte();
        return 8'($urandom_range(255));
    endfunction

    // bitwise form: feed one data bit per shift
    function automatic logic [15:0] crc16_reflect_step(input logic [15:0] acc,
                                                       input logic [7:0]  data);
        logic [15:0] c;
        logic        fb;
        c = acc;
        for (int i = 0; i < 8; i++)
        begin
            fb = c[0] ^ data[i];
            c  = {1'b0, c[15:1]} ^ (fb ? sfd_pkg::CRC_POLY : 16'h0000);
        end
        return c;
    endfunction

    task automatic deframe_predict(input logic [7:0] b, input logic hs, input logic hf,
                                   output deframe_result_t r);
        logic is_fast;
        int   flen;
        r      = '0;
        r.kind = sfd_pkg::EV_NONE;
        r.val  = b;
        flen   = in_fast_frame ? FAST_LEN : SLOW_LEN;
        unique case (parse_mode)
            sfd_pkg::MODE_HEADER:
            begin
                if (b == reg_header)
                begin
                    parse_mode    = sfd_pkg::MODE_ID;
                    payload_count = 6'd0;
                    in_fast_frame = 1'b0;
                    run_crc       = crc16_reflect_step(sfd_pkg::CRC_INIT, b);
                end
            end
            sfd_pkg::MODE_ID:
            begin
                if (b == reg_slow_id || b == reg_fast_id)
                begin
                    is_fast = (b != reg_slow_id);
                    if (is_fast ? hf : hs)
                    begin
                        parse_mode = sfd_pkg::MODE_HEADER;
                        r.kind     = sfd_pkg::EV_DROP;
                        r.fk       = is_fast;
                    end
                    else
                    begin
                        in_fast_frame = is_fast;
                        payload_count = 6'd0;
                        parse_mode    = sfd_pkg::MODE_DATA;
                        run_crc       = crc16_reflect_step(run_crc, b);
                    end
                end
                else
                    parse_mode = sfd_pkg::MODE_HEADER;
            end
            sfd_pkg::MODE_DATA:
            begin
                run_crc       = crc16_reflect_step(run_crc, b);
                r.kind        = sfd_pkg::EV_PAYLOAD;
                r.fk          = in_fast_frame;
                r.idx         = payload_count;
                payload_count = payload_count + 6'd1;
                if (payload_count >= flen)
                    parse_mode = sfd_pkg::MODE_CRC;
            end
            default:
            begin
                r.fk  = in_fast_frame;
                r.idx = payload_count;
                if (payload_count == flen)
                begin
                    heard_crc[15:8] = b;
                    payload_count   = payload_count + 6'd1;
                    r.kind          = sfd_pkg::EV_CRC_HI;
                end
                else
                begin
                    heard_crc[7:0] = b;
                    r.kind         = (heard_crc == run_crc) ? sfd_pkg::EV_GOOD
                                                            : sfd_pkg::EV_BAD;
                    parse_mode     = sfd_pkg::MODE_HEADER;
                end
            end
        endcase
        r.crc = run_crc;
    endtask

    // Offer one byte, wait for the transfer, then log what it must produce.
    task automatic transfer_byte(input logic [7:0] b, input logic hs, input logic hf,
                                 input bit pin = 1'b0,
                                 input sfd_pkg::event_t pin_kind = sfd_pkg::EV_NONE,
                                 input logic pin_fk = 1'b0, input logic [5:0] pin_idx = 6'd0);
        deframe_result_t want;
        while ($urandom_range(99) < src_gap_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid  <= 1'b1;
        rx_byte   <= b;
        hold_slow <= hs;
        hold_fast <= hf;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        deframe_predict(b, hs, hf, want);
        if (pin)
        begin
            want.kind = pin_kind;
            want.fk   = pin_fk;
            want.idx  = pin_idx;
        end
        pending_results.push_back(want);
        bytes_taken++;
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic load_registers(input logic [7:0] h, input logic [7:0] s,
                                  input logic [7:0] f, input logic [7:0] spare);
        sfd_pkg::cfg_index_t reg_list [4];
        logic [7:0]          reg_vals [4];
        reg_list = '{sfd_pkg::CFG_HEADER, sfd_pkg::CFG_SLOW_ID, sfd_pkg::CFG_FAST_ID,
                     sfd_pkg::CFG_SPARE};
        reg_vals = '{h, s, f, spare};
        for (int i = 0; i < 4; i++)
        begin
            cfg_write <= 1'b1;
            cfg_index <= reg_list[i];
            cfg_data  <= reg_vals[i];
            @(posedge clk);
        end
        cfg_write   <= 1'b0;
        // the spare index has no register behind it
        reg_header  = h;
        reg_slow_id = s;
        reg_fast_id = f;
    endtask

    task automatic send_frame();
        logic        is_fast;
        logic        held;
        logic        hs;
        logic        hf;
        logic [7:0]  id;
        logic [7:0]  b;
        logic [15:0] crc;
        int          flen;
        is_fast = rand_bit();
        id      = is_fast ? reg_fast_id : reg_slow_id;
        is_fast = (id != reg_slow_id);
        held    = ($urandom_range(99) < 12);
        hs      = rand_bit();
        hf      = rand_bit();
        if (is_fast)
            hf = held;
        else
            hs = held;
        crc = crc16_reflect_step(sfd_pkg::CRC_INIT, reg_header);
        transfer_byte(reg_header, rand_bit(), rand_bit());
        transfer_byte(id, hs, hf);
        if (!held)
        begin
            crc  = crc16_reflect_step(crc, id);
            flen = is_fast ? FAST_LEN : SLOW_LEN;
            repeat (flen)
            begin
                b   = rand_byte();
                crc = crc16_reflect_step(crc, b);
                transfer_byte(b, rand_bit(), rand_bit());
            end
            if ($urandom_range(99) < 10)
                crc = crc ^ (16'd1 << $urandom_range(15));
            transfer_byte(crc[15:8], rand_bit(), rand_bit());
            transfer_byte(crc[7:0], rand_bit(), rand_bit());
        end
    endtask

    task automatic send_noise();
        int         pick;
        int         n;
        logic [7:0] id;
        pick = $urandom_range(3);
        unique case (pick)
            0:
            begin
                n = $urandom_range(6, 1);
                repeat (n)
                    transfer_byte(rand_byte(), rand_bit(), rand_bit());
            end
            1:
            begin
                transfer_byte(reg_header, rand_bit(), rand_bit());
                transfer_byte(rand_byte(), rand_bit(), rand_bit());
            end
            2:
            begin
                // frame cut short: whatever follows is eaten as payload
                id = rand_bit() ? reg_fast_id : reg_slow_id;
                transfer_byte(reg_header, rand_bit(), rand_bit());
                transfer_byte(id, 1'b0, 1'b0);
                n = $urandom_range(SLOW_LEN - 1, 1);
                repeat (n)
                    transfer_byte(rand_byte(), rand_bit(), rand_bit());
            end
            default:
            begin
                transfer_byte(reg_header, rand_bit(), rand_bit());
                transfer_byte(reg_header, rand_bit(), rand_bit());
            end
        endcase
    endtask

    function automatic void check_field(input string what, input logic [15:0] want,
                                        input logic [15:0] got);
        if (got !== want)
        begin
            mismatches++;
            $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, what, want, got);
        end
    endfunction

    always @(posedge clk)
    begin : result_check
        deframe_result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_results.size() == 0)
            begin
                mismatches++;
                $display("%0t ns: result with none expected, expected nothing, actual event %0d",
                         $time, event_kind);
            end
            else
            begin
                want = pending_results.pop_front();
                check_field("event_kind", 16'(want.kind), 16'(event_kind));
                check_field("frame_kind", 16'(want.fk), 16'(frame_kind));
                check_field("byte_index", 16'(want.idx), 16'(byte_index));
                check_field("byte_value", 16'(want.val), 16'(byte_value));
                check_field("computed_crc", want.crc, computed_crc);
            end
        end
        out_stall <= ($urandom_range(99) < sink_stall_pct);
    end

    initial
    begin
        stim_row_t  row;
        logic [7:0] b;
        logic [7:0] s_val;
        logic [7:0] f_val;
        int         mark;
        rst_n     <= 1'b0;
        in_valid  <= 1'b0;
        rx_byte   <= 8'h00;
        hold_slow <= 1'b0;
        hold_fast <= 1'b0;
        cfg_write <= 1'b0;
        cfg_index <= sfd_pkg::CFG_HEADER;
        cfg_data  <= 8'h00;
        src_gap_pct    = 9;
        sink_stall_pct = 61;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[r])
        begin
            row = directed_rows[r];
            for (int k = 0; k < row.reps; k++)
            begin
                unique case (row.src)
                    SRC_LIT:    b = row.lit;
                    SRC_CRC_HI: b = run_crc[15:8];
                    SRC_CRC_LO: b = run_crc[7:0];
                    default:    b = run_crc[7:0] ^ 8'h01;
                endcase
                transfer_byte(b, row.hs, row.hf, row.pinned, row.kind, row.fk, row.idx);
            end
        end

        for (int ph = 0; ph < 3; ph++)
        begin
            drain_results();
            unique case (ph)
                0:
                    load_registers(8'hFF, 8'h00, 8'hFF, rand_byte());
                1:
                begin
                    src_gap_pct    = 61;
                    sink_stall_pct = 9;
                    s_val = rand_byte();
                    do
                        f_val = rand_byte();
                    while (f_val == s_val);
                    load_registers(rand_byte(), s_val, f_val, rand_byte());
                end
                default:
                begin
                    src_gap_pct    = 0;
                    sink_stall_pct = 0;
                    load_registers(8'h00, 8'hFF, 8'h00, rand_byte());
                end
            endcase
            mark = bytes_taken;
            while (bytes_taken - mark < 270)
            begin
                if ($urandom_range(99) < 75)
                    send_frame();
                else
                    send_noise();
            end
        end

        drain_results();
        repeat (6) @(posedge clk);
        if (mismatches == 0 && pending_results.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    initial
    begin
        #5000000;
        $display("FAILURE");
        $finish;
    end

endmodule
